### design/chist_pkg.sv
package chist_pkg;

	localparam int NUM_BINS    = 256;
	localparam int BIN_W       = $clog2(NUM_BINS);
	localparam int COUNT_WIDTH = 32;
	localparam int OUT_WIDTH   = 32;

	typedef logic [BIN_W-1:0]       bin_t;
	typedef logic [COUNT_WIDTH-1:0] count_t;
	typedef logic [OUT_WIDTH-1:0]   out_t;

	typedef enum logic [1:0] {
		MODE_ACC   = 2'd0,
		MODE_READ  = 2'd1,
		MODE_CLEAR = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		CH_RED   = 2'd0,
		CH_GREEN = 2'd1,
		CH_BLUE  = 2'd2,
		CH_GRAY  = 2'd3
	} chan_t;

	typedef struct packed {
		logic en;
		bin_t addr;
	} rd_req_t;

	typedef struct packed {
		logic   en;
		bin_t   addr;
		count_t data;
	} wr_req_t;

	// clamp a count onto the output field
	function automatic out_t to_out(input count_t v);
		logic [63:0] wide;
		wide = 64'(v);
		return (wide > 64'(out_t'('1))) ? out_t'('1) : wide[OUT_WIDTH-1:0];
	endfunction

endpackage

### design/chist_bin_store.sv
module chist_bin_store
	import chist_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  rd_req_t rd,
	input  wr_req_t wr,
	input  logic    clr,
	output count_t  rd_data
);

	count_t                mem_q [NUM_BINS];
	count_t                rd_data_q;
	logic                  rd_vld_q;
	logic [NUM_BINS-1:0]   vld_q;
	logic                  same_addr;

	assign same_addr = wr.en && (wr.addr == rd.addr);

	// write-first: a read in the cycle of a write to the same bin sees the new count
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
		if (rd.en) begin
			rd_data_q <= same_addr ? wr.data : mem_q[rd.addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (rd.en) begin
				rd_vld_q <= clr ? 1'b0 : (same_addr ? 1'b1 : vld_q[rd.addr]);
			end
			if (clr) begin
				vld_q <= '0;
			end else if (wr.en) begin
				vld_q[wr.addr] <= 1'b1;
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_data_q : '0;

endmodule

### design/channel_histogram_engine.sv
// An accepted word waits in stage 1 while its bin is read, then its result is registered.
// Throughput: one word per cycle when not stalled; the bin memory has one read and one write
// port: one read and one write-back per cycle, same-bin reads bypassed from the write port.
// Reset: all bins read as zero and the maximum is zero at once (per-bin valid flags);
// channel select resets to gray. No clearing pass is needed.
module channel_histogram_engine
	import chist_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] mode,
	input  logic [7:0] red,
	input  logic [7:0] green,
	input  logic [7:0] blue,
	input  logic [7:0] bin_index,
	output logic       out_valid,
	input  logic       out_stall,
	output out_t       bin_count,
	output out_t       max_count
);

	chan_t      chan_q;
	logic       vld_s1;
	logic [1:0] mode_s1;
	count_t     peak_q;
	logic       out_vld_q;
	out_t       bin_count_q;
	out_t       max_count_q;

	logic       accept;
	logic       advance;
	logic [12:0] gray_sum;
	bin_t       pix_bin;
	rd_req_t    rd;
	wr_req_t    wr;
	logic       clr;
	count_t     cur;
	count_t     inc;
	count_t     peak_new;
	bin_t       addr_s1;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_q <= CH_GRAY;
		end else if (cfg_valid) begin
			chan_q <= chan_t'(cfg_data);
		end
	end

	assign advance  = !out_vld_q || !out_stall;
	assign in_stall = vld_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	assign gray_sum = 13'(red) * 13'd11 + 13'(green) * 13'd16 + 13'(blue) * 13'd5;

	always_comb begin
		unique case (chan_q)
			CH_RED:   pix_bin = bin_t'(red);
			CH_GREEN: pix_bin = bin_t'(green);
			CH_BLUE:  pix_bin = bin_t'(blue);
			CH_GRAY:  pix_bin = bin_t'(gray_sum[12:5]);
			default:  pix_bin = bin_t'(gray_sum[12:5]);
		endcase
	end

	assign rd.en   = accept;
	assign rd.addr = (mode_t'(mode) == MODE_READ) ? bin_t'(bin_index) : pix_bin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (advance) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1 <= mode;
			addr_s1 <= rd.addr;
		end
	end

	chist_bin_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd      (rd),
		.wr      (wr),
		.clr     (clr),
		.rd_data (cur)
	);

	assign inc      = (cur == '1) ? cur : cur + COUNT_WIDTH'(1);
	assign peak_new = (inc > peak_q) ? inc : peak_q;

	assign wr.en   = vld_s1 && advance && (mode_t'(mode_s1) == MODE_ACC);
	assign wr.addr = addr_s1;
	assign wr.data = inc;
	assign clr     = vld_s1 && advance && (mode_t'(mode_s1) == MODE_CLEAR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q <= '0;
		end else if (clr) begin
			peak_q <= '0;
		end else if (wr.en) begin
			peak_q <= peak_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (advance) begin
			out_vld_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1 && advance) begin
			unique case (mode_s1)
				MODE_ACC: begin
					bin_count_q <= to_out(inc);
					max_count_q <= to_out(peak_new);
				end
				MODE_READ: begin
					bin_count_q <= to_out(cur);
					max_count_q <= to_out(peak_q);
				end
				MODE_CLEAR: begin
					bin_count_q <= '0;
					max_count_q <= '0;
				end
				default: begin
					bin_count_q <= '0;
					max_count_q <= to_out(peak_q);
				end
			endcase
		end
	end

	assign out_valid = out_vld_q;
	assign bin_count = bin_count_q;
	assign max_count = max_count_q;

	a_stall_only_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> vld_s1)
		else $error("input stalled with empty stage");

	a_clear_gives_zero: assert property (@(posedge clk) disable iff (!arst_n)
		clr |=> (bin_count == '0) && (max_count == '0) && out_valid)
		else $error("clear result not zero");

	a_acc_within_max: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |=> (max_count >= bin_count) && out_valid)
		else $error("bin count above maximum");

	a_peak_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		!clr |=> peak_q >= $past(peak_q))
		else $error("maximum fell without clear");

endmodule
